[rtl/core/spectral_bin_delay_feedback_macros.svh]
// Assertion macros shared by the spectral delay block.
`ifndef SPECTRAL_BIN_DELAY_FEEDBACK_MACROS_SVH
`define SPECTRAL_BIN_DELAY_FEEDBACK_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SBDF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SBDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/sbdf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sbdf_pkg;

	localparam int BINS     = 512;
	localparam int FRAMES   = 64;
	localparam int DEPTH    = FRAMES * BINS;

	localparam int SAMPLE_W = 24;
	localparam int GAIN_W   = 17;
	localparam int DELAY_W  = 6;
	localparam int CFG_W    = 6;
	localparam int CFG_IDX_W = 2;

	localparam int BIN_W    = $clog2(BINS);
	localparam int FRAME_W  = $clog2(FRAMES);
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int FSUM_W   = ((FRAME_W > DELAY_W) ? FRAME_W : DELAY_W) + 1;
	localparam int PROD_W   = SAMPLE_W + GAIN_W;
	localparam int FRAC_W   = 15;
	localparam int SUM_W    = PROD_W - FRAC_W + 2;

	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_BYPASS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_BYPASS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY       = 2'd3;

	localparam logic [DELAY_W-1:0] MAX_DELAY_RESET = 6'd63;

	typedef logic signed [SAMPLE_W-1:0] q23_t;
	typedef logic signed [GAIN_W-1:0]   gain_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic [ADDR_W-1:0]          addr_t;

	typedef struct packed {
		q23_t    re;
		q23_t    im;
		gain_t   gain;
		addr_t   waddr;
		logic    we;
		logic    skip;
		logic    byp;
		logic    self_hit;
		logic    bin0;
		logic    last;
	} st1_t;

	typedef struct packed {
		q23_t    re;
		q23_t    im;
		q23_t    cre;
		q23_t    cim;
		prod_t   prod_re;
		prod_t   prod_im;
		addr_t   waddr;
		logic    we;
		logic    skip;
		logic    byp;
		logic    self_hit;
		logic    bin0;
		logic    last;
	} st2_t;

	// slot address of a bin within a frame
	function automatic addr_t slot_addr(input logic [FRAME_W-1:0] frame,
			input logic [BIN_W-1:0] bin);
		slot_addr = ADDR_W'(frame * BINS + bin);
	endfunction

	// x + round(p / 2^15), ties upward, saturated to the sample range
	function automatic q23_t fb_sat(input q23_t x, input prod_t p);
		logic [PROD_W:0]  pr;
		logic [SUM_W-1:0] s;
		pr = {p[PROD_W-1], p} + (PROD_W + 1)'(1 << (FRAC_W - 1));
		s = {pr[PROD_W], pr[PROD_W:FRAC_W]}
			+ {{(SUM_W - SAMPLE_W){x[SAMPLE_W-1]}}, x};
		if ((&s[SUM_W-1:SAMPLE_W-1]) || !(|s[SUM_W-1:SAMPLE_W-1])) begin
			fb_sat = s[SAMPLE_W-1:0];
		end else if (s[SUM_W-1]) begin
			fb_sat = {1'b1, {(SAMPLE_W - 1){1'b0}}};
		end else begin
			fb_sat = {1'b0, {(SAMPLE_W - 1){1'b1}}};
		end
	endfunction

endpackage

`default_nettype wire

[rtl/core/spectral_bin_delay_feedback.sv]
// Per-bin spectral delay with feedback over a ring of FFT frames.
// Input channel (in_valid / in_stall): one complex bin per item with its own
// delay in frames and feedback gain; last_bin closes the frame and advances
// the frame pointer. Output channel (out_valid / out_stall): one item per
// input item, in order, with frame_end copied from last_bin.
// Configuration (cfg_we, cfg_index, cfg_data) is written while idle.
// The user is bound to this; the block itself does not enforce it.
// A taken item passes through stage one (memory read and multiply), stage
// two (round/add/saturate and write back) and then the output register,
// from which the receiver takes it. Throughput: one item per cycle while
// in_stall is low. The bin store is a single-port-write, single-read
// memory; in_stall rises when the slot the next bin reads is still to be
// written by one of the two items ahead, which only happens in frames of
// one or two bins. Reset: the store is swept to zero, one slot per cycle,
// with in_stall high; configuration writes are taken during the sweep.
// A stalled output holds its item; the stages behind fill up and then
// in_stall rises, so no item is lost.
`timescale 1ns / 1ps
`default_nettype none
`include "spectral_bin_delay_feedback_macros.svh"

module spectral_bin_delay_feedback (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [sbdf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sbdf_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic signed [sbdf_pkg::SAMPLE_W-1:0] real_part,
	input  wire logic signed [sbdf_pkg::SAMPLE_W-1:0] imag_part,
	input  wire logic [sbdf_pkg::DELAY_W-1:0]     delay_frames,
	input  wire logic signed [sbdf_pkg::GAIN_W-1:0] feedback_gain,
	input  wire logic                             last_bin,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic signed [sbdf_pkg::SAMPLE_W-1:0]  real_out,
	output logic signed [sbdf_pkg::SAMPLE_W-1:0]  imag_out,
	output logic                                  frame_end
);
	import sbdf_pkg::*;

	logic                 delay_bypass_q;
	logic                 feedback_bypass_q;
	logic [DELAY_W-1:0]   min_delay_q;
	logic [DELAY_W-1:0]   max_delay_q;

	logic [FRAME_W-1:0]   wf_q;
	logic [BIN_W-1:0]     bin_q;
	logic                 clearing_q;
	addr_t                clr_addr_q;

	logic [2*SAMPLE_W-1:0] mem [DEPTH];
	logic [2*SAMPLE_W-1:0] rd_s1;

	st1_t                 st_s1;
	logic                 vld_s1;
	st2_t                 st_s2;
	logic                 vld_s2;

	q23_t                 real_out_q;
	q23_t                 imag_out_q;
	logic                 frame_end_q;
	logic                 out_valid_q;

	logic                 out_free;
	logic                 adv1;
	logic                 adv2;
	logic                 s1_free;
	logic                 s2_free;
	logic                 hazard;
	logic                 accept;
	addr_t                cur_addr;
	st1_t                 st1_c;
	st2_t                 st2_c;
	q23_t                 new_re;
	q23_t                 new_im;
	q23_t                 res_re;
	q23_t                 res_im;
	logic                 mem_we;
	addr_t                mem_waddr;
	logic [2*SAMPLE_W-1:0] mem_wdata;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_bypass_q    <= 1'b0;
			feedback_bypass_q <= 1'b0;
			min_delay_q       <= '0;
			max_delay_q       <= MAX_DELAY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DELAY_BYPASS:    delay_bypass_q    <= cfg_data[0];
				CFG_FEEDBACK_BYPASS: feedback_bypass_q <= cfg_data[0];
				CFG_MIN_DELAY:       min_delay_q       <= cfg_data[DELAY_W-1:0];
				CFG_MAX_DELAY:       max_delay_q       <= cfg_data[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake and interlock
	assign out_free = !out_valid_q || !out_stall;
	assign adv2     = vld_s2 && out_free;
	assign s2_free  = !vld_s2 || adv2;
	assign adv1     = vld_s1 && s2_free;
	assign s1_free  = !vld_s1 || adv1;
	assign cur_addr = slot_addr(wf_q, bin_q);
	assign hazard   = (vld_s1 && st_s1.we && st_s1.waddr == cur_addr)
		|| (vld_s2 && st_s2.we && st_s2.waddr == cur_addr);
	assign in_stall = clearing_q || !s1_free || hazard;
	assign accept   = in_valid && !in_stall;

	// entry stage: clamp delay and gain, work out the destination slot
	always_comb begin
		logic [DELAY_W-1:0] d_eff;
		logic               g_zero;
		logic [FRAME_W-1:0] dest_frame;
		addr_t              dest;
		d_eff  = delay_frames;
		g_zero = feedback_bypass_q || feedback_gain[GAIN_W-1];
		if (delay_frames > max_delay_q) begin
			d_eff = max_delay_q;
		end else if (delay_frames <= min_delay_q) begin
			d_eff  = min_delay_q;
			g_zero = 1'b1;
		end
		dest_frame = FRAME_W'((FSUM_W'(wf_q) + FSUM_W'(d_eff)) % FRAMES);
		dest       = slot_addr(dest_frame, bin_q);
		st1_c.re       = real_part;
		st1_c.im       = imag_part;
		st1_c.gain     = g_zero ? '0 : feedback_gain;
		st1_c.skip     = (bin_q == BIN_W'(BINS - 1));
		st1_c.we       = !st1_c.skip;
		st1_c.byp      = delay_bypass_q;
		st1_c.waddr    = delay_bypass_q ? cur_addr : dest;
		st1_c.self_hit = (dest == cur_addr);
		st1_c.bin0     = (bin_q == '0);
		st1_c.last     = last_bin;
	end

	// frame pointer, bin counter and clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wf_q       <= '0;
			bin_q      <= '0;
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
				if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (accept) begin
				if (last_bin) begin
					bin_q <= '0;
					wf_q  <= FRAME_W'((FSUM_W'(wf_q) + FSUM_W'(1)) % FRAMES);
				end else if (bin_q != BIN_W'(BINS - 1)) begin
					bin_q <= bin_q + BIN_W'(1);
				end
			end
		end
	end

	// bin store: read the current slot on entry, write back from stage two (zeros during the clearing sweep)
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= mem[cur_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	// stage one: feedback products on the current slot
	always_comb begin
		st2_c.re       = st_s1.re;
		st2_c.im       = st_s1.im;
		st2_c.cre      = rd_s1[2*SAMPLE_W-1:SAMPLE_W];
		st2_c.cim      = rd_s1[SAMPLE_W-1:0];
		st2_c.prod_re  = st2_c.cre * st_s1.gain;
		st2_c.prod_im  = st2_c.cim * st_s1.gain;
		st2_c.waddr    = st_s1.waddr;
		st2_c.we       = st_s1.we;
		st2_c.skip     = st_s1.skip;
		st2_c.byp      = st_s1.byp;
		st2_c.self_hit = st_s1.self_hit;
		st2_c.bin0     = st_s1.bin0;
		st2_c.last     = st_s1.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s1_free) begin
				vld_s1 <= accept;
			end
			if (s2_free) begin
				vld_s2 <= adv1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			st_s1 <= st1_c;
		end
		if (adv1) begin
			st_s2 <= st2_c;
		end
	end

	// stage two: round, add, saturate; pick the result
	always_comb begin
		new_re = st_s2.byp ? st_s2.re : fb_sat(st_s2.re, st_s2.prod_re);
		if (st_s2.bin0) begin
			new_im = '0;
		end else begin
			new_im = st_s2.byp ? st_s2.im : fb_sat(st_s2.im, st_s2.prod_im);
		end
		if (st_s2.skip) begin
			res_re = st_s2.re;
			res_im = st_s2.im;
		end else if (st_s2.byp || st_s2.self_hit) begin
			res_re = new_re;
			res_im = new_im;
		end else begin
			res_re = st_s2.cre;
			res_im = st_s2.bin0 ? '0 : st_s2.cim;
		end
	end

	assign mem_we    = clearing_q || (adv2 && st_s2.we);
	assign mem_waddr = clearing_q ? clr_addr_q : st_s2.waddr;
	assign mem_wdata = clearing_q ? '0 : {new_re, new_im};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			real_out_q  <= res_re;
			imag_out_q  <= res_im;
			frame_end_q <= st_s2.last;
		end
	end

	assign out_valid = out_valid_q;
	assign real_out  = real_out_q;
	assign imag_out  = imag_out_q;
	assign frame_end = frame_end_q;

	`SBDF_ASSERT_NOW(a_no_write_in_sweep, clk, arst_n, adv2 && st_s2.we, !clearing_q, "pipeline write during clearing sweep")
	`SBDF_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, accept, vld_s1, "accepted item missing from stage one")
	`SBDF_ASSERT_NEXT(a_bin_advance, clk, arst_n, accept && !last_bin && bin_q != BIN_W'(BINS - 1), bin_q == $past(bin_q) + BIN_W'(1), "bin counter failed to advance")
	`SBDF_ASSERT_NOW(a_no_read_of_pending, clk, arst_n, accept && vld_s2 && st_s2.we, st_s2.waddr != cur_addr, "slot read before pending write")

endmodule

`default_nettype wire
